// File: rtl/tsd_pkg.sv
// tsd_pkg: shared types, codes and constants for the thermometer scratchpad decoder
// no dependencies; compiled first
`timescale 1ns / 1ps

package tsd_pkg;

   localparam int unsigned RomBits      = 64;
   localparam int unsigned CrcDataBits  = 56;
   localparam int unsigned CrcBits      = 8;
   localparam int unsigned TempBits     = 16;

   localparam logic [CrcBits-1:0] CRC_POLY_REFLECTED = 8'h8C;

   // family codes in rom byte 0
   localparam logic [7:0] FAMILY_OLD   = 8'h10;
   localparam logic [7:0] FAMILY_NEW   = 8'h28;
   localparam logic [7:0] FAMILY_THIRD = 8'h22;

   // old part refinement
   localparam logic [7:0]          OLD_FULL_COUNT  = 8'h10;
   localparam logic [TempBits-1:0] TEMP_WHOLE_MASK = 16'hFFF0;
   localparam logic [TempBits-1:0] OLD_REFINE_BIAS = 16'd12;

   // resolution field of the configuration byte
   localparam int unsigned ResFieldLsb = 5;
   localparam int unsigned ResFieldMsb = 6;

   typedef enum logic [1:0] {
      RES_9BIT  = 2'b00,
      RES_10BIT = 2'b01,
      RES_11BIT = 2'b10,
      RES_12BIT = 2'b11
   } tsd_resolution_type;

   typedef enum logic [2:0] {
      STATUS_CRC_ERROR = 3'd0,
      STATUS_OLD       = 3'd1,
      STATUS_NEW       = 3'd2,
      STATUS_THIRD     = 3'd3,
      STATUS_UNKNOWN   = 3'd4
   } tsd_status_type;

   typedef struct packed {
      logic [RomBits-1:0] rom_code;
      logic [7:0]         temp_low;
      logic [7:0]         temp_high;
      logic [7:0]         config_byte;
      logic [7:0]         count_remain;
      logic [7:0]         count_per_degree;
   } tsd_reading_type;

   typedef struct packed {
      tsd_status_type             status;
      logic                       temp_valid;
      logic signed [TempBits-1:0] temperature;
   } tsd_result_type;

   typedef logic [CrcDataBits-1:0][CrcBits-1:0] tsd_crc_columns_type;

   // crc contribution of each single data bit; the crc is linear with a zero
   // start value, so the full crc is the xor of the columns of the set bits
   function automatic tsd_crc_columns_type crc_columns();
      tsd_crc_columns_type cols;
      logic [CrcBits-1:0]  crc;
      logic                mix;
      for (int j = 0; j < CrcDataBits; j++) begin
         crc = '0;
         for (int i = 0; i < CrcDataBits; i++) begin
            mix = crc[0] ^ (i == j);
            crc = crc >> 1;
            if (mix) begin
               crc = crc ^ CRC_POLY_REFLECTED;
            end
         end
         cols[j] = crc;
      end
      return cols;
   endfunction

endpackage

// File: rtl/tsd_if.sv
// tsd_if: valid/ready channel interfaces for readings and decoded results
// widths follow the field list of the decoder; no package dependency
`timescale 1ns / 1ps

interface tsd_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] rom_code;
   logic [7:0]  temp_low;
   logic [7:0]  temp_high;
   logic [7:0]  config_byte;
   logic [7:0]  count_remain;
   logic [7:0]  count_per_degree;

   modport source (
      output valid, rom_code, temp_low, temp_high, config_byte, count_remain,
             count_per_degree,
      input  ready
   );
   modport sink (
      input  valid, rom_code, temp_low, temp_high, config_byte, count_remain,
             count_per_degree,
      output ready
   );
endinterface

interface tsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic               temp_valid;
   logic signed [15:0] temperature;

   modport source (
      output valid, status, temp_valid, temperature,
      input  ready
   );
   modport sink (
      input  valid, status, temp_valid, temperature,
      output ready
   );
endinterface

// File: rtl/tsd_decode.sv
// tsd_decode: rom crc-8 check and family-dependent temperature conversion
// pure combinational; depends on tsd_pkg
`timescale 1ns / 1ps

module tsd_decode
   import tsd_pkg::*;
(
   input  tsd_reading_type reading,
   output tsd_result_type  result
);

   localparam tsd_crc_columns_type CrcColumns = crc_columns();

   logic [CrcBits-1:0]  crc_calc;
   logic                crc_ok;
   logic [7:0]          family;
   logic [TempBits-1:0] raw;
   logic [TempBits-1:0] old_shifted;
   logic [TempBits-1:0] old_temp;
   logic [TempBits-1:0] masked;
   tsd_resolution_type  resolution;

   // xor of independent per-bit columns
   always_comb begin
      crc_calc = '0;
      for (int j = 0; j < CrcDataBits; j++) begin
         if (reading.rom_code[j]) begin
            crc_calc = crc_calc ^ CrcColumns[j];
         end
      end
   end

   assign crc_ok = (crc_calc == reading.rom_code[RomBits-1 -: CrcBits]);
   assign family = reading.rom_code[7:0];
   assign raw    = {reading.temp_high, reading.temp_low};

   assign old_shifted = {raw[TempBits-4:0], 3'b000};
   assign old_temp    = (reading.count_per_degree == OLD_FULL_COUNT)
                      ? (old_shifted & TEMP_WHOLE_MASK) + OLD_REFINE_BIAS
                        - {8'h00, reading.count_remain}
                      : old_shifted;

   assign resolution = tsd_resolution_type'(reading.config_byte[ResFieldMsb:ResFieldLsb]);

   always_comb begin
      unique case (resolution)
         RES_9BIT:  masked = raw & 16'hFFF8;
         RES_10BIT: masked = raw & 16'hFFFC;
         RES_11BIT: masked = raw & 16'hFFFE;
         RES_12BIT: masked = raw;
         default:   masked = raw;
      endcase
   end

   always_comb begin
      result.temp_valid = 1'b1;
      priority if (!crc_ok) begin
         result.status      = STATUS_CRC_ERROR;
         result.temp_valid  = 1'b0;
         result.temperature = '0;
      end else if (family == FAMILY_OLD) begin
         result.status      = STATUS_OLD;
         result.temperature = old_temp;
      end else if (family == FAMILY_NEW) begin
         result.status      = STATUS_NEW;
         result.temperature = masked;
      end else if (family == FAMILY_THIRD) begin
         result.status      = STATUS_THIRD;
         result.temperature = masked;
      end else begin
         result.status      = STATUS_UNKNOWN;
         result.temperature = raw;
      end
   end

endmodule

// File: rtl/thermometer_scratchpad_decode.sv
// thermometer_scratchpad_decode: top level of the scratchpad decoder
// depends on tsd_pkg, tsd_if (tsd_req_if, tsd_rsp_if) and tsd_decode
//
// Each item on req_chan is one sensor reading: the 64-bit rom code and the
// scratchpad bytes. The rom code is checked with the 1-wire crc-8 over bytes
// 0..6 against byte 7; a mismatch returns status crc error with temp_valid
// low and temperature zero. Otherwise the family byte selects the conversion
// to a 16-bit signed temperature in sixteenths of a degree: the old 9-bit
// part is shifted left by three and refined from count_remain when
// count_per_degree is 0x10, newer parts are masked to their resolution, an
// unknown family passes the raw word through. Exactly one result item leaves
// on rsp_chan per reading, in order. One item is taken every cycle as long as
// rsp_chan does not stall; each reading passes the input register, then the
// result register, and the decode in between is a single short combinational
// pass. A stalled rsp_chan holds the result register and backs up into the
// input register, so req_chan keeps accepting until both are full.
`timescale 1ns / 1ps

module thermometer_scratchpad_decode
   import tsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tsd_req_if.sink   req_chan,
   tsd_rsp_if.source rsp_chan
);

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   tsd_reading_type in_data_ff;

   // result register
   logic            out_valid_ff;
   logic            out_valid_in;
   tsd_result_type  out_data_ff;

   tsd_result_type  decoded;
   tsd_reading_type req_reading;
   logic            out_free;
   logic            in_take;
   logic            req_fire;

   // result register can load when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign in_take  = in_valid_ff && out_free;

   // input register can load when empty or moving forward
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req_reading.rom_code         = req_chan.rom_code;
   assign req_reading.temp_low         = req_chan.temp_low;
   assign req_reading.temp_high        = req_chan.temp_high;
   assign req_reading.config_byte      = req_chan.config_byte;
   assign req_reading.count_remain     = req_chan.count_remain;
   assign req_reading.count_per_degree = req_chan.count_per_degree;

   assign in_valid_in  = req_fire || (in_valid_ff && !out_free);
   assign out_valid_in = in_take || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_reading;
      end
      if (in_take) begin
         out_data_ff <= decoded;
      end
   end

   // crc check and conversion
   tsd_decode u_decode (
      .reading (in_data_ff),
      .result  (decoded)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_data_ff.status;
   assign rsp_chan.temp_valid  = out_data_ff.temp_valid;
   assign rsp_chan.temperature = out_data_ff.temperature;

`ifndef SYNTHESIS
   // a taken reading sits in the input register next cycle
   assert_in_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted item not held in input register");

   // a reading that moves forward shows up as a result
   assert_out_load: assert property (@(posedge clock) disable iff (reset)
      in_take |=> out_valid_ff)
      else $error("decoded item lost before result register");

   // temp_valid low exactly on crc error
   assert_valid_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.temp_valid ==
                        (out_data_ff.status != STATUS_CRC_ERROR)))
      else $error("temp_valid disagrees with status");

   // crc error carries a zero temperature
   assert_crc_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.temp_valid) |-> (out_data_ff.temperature == '0))
      else $error("crc error with nonzero temperature");
`endif

endmodule
